[hw/rtl/cbc_pkg.sv]
`timescale 1ns / 1ps

package cbc_pkg;

	// Longest message that is accumulated; later bytes only raise overflow.
	localparam int MAX_BYTES = 4096;

	localparam int MODE_W  = 4;
	localparam int BYTES_W = $clog2(MAX_BYTES + 1);
	localparam int SUM_W   = $clog2(MAX_BYTES * 255 + 1);
	localparam int CNT_W   = $clog2(MAX_BYTES * 8 + 1);
	localparam int SHIFT_W = $clog2(SUM_W);

	typedef enum logic [MODE_W-1:0] {
		MODE_SUM_RIGHT          = 4'd0,
		MODE_SUM_LEFT           = 4'd1,
		MODE_XOR                = 4'd2,
		MODE_COUNT1_RIGHT       = 4'd3,
		MODE_COUNT1_LEFT        = 4'd4,
		MODE_COUNT0_RIGHT       = 4'd5,
		MODE_COUNT0_LEFT        = 4'd6,
		MODE_FLIP_SUM_RIGHT     = 4'd7,
		MODE_FLIP_SUM_LEFT      = 4'd8,
		MODE_REV_SUM_RIGHT      = 4'd9,
		MODE_REV_SUM_LEFT       = 4'd10,
		MODE_FLIP_REV_SUM_RIGHT = 4'd11,
		MODE_FLIP_REV_SUM_LEFT  = 4'd12,
		MODE_FLIP_REV_XOR       = 4'd13
	} mode_t;

	typedef enum logic [2:0] {
		OP_SUM_R,
		OP_SUM_L,
		OP_XOR,
		OP_C1_R,
		OP_C1_L,
		OP_C0_R,
		OP_C0_L,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic flip;
		logic rev;
	} tf_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] check_byte;
		logic       overflow;
	} out_item_t;

	// Final accumulator values of one message, handed to the result stage.
	typedef struct packed {
		logic               valid;
		logic [SUM_W-1:0]   sum;
		logic [7:0]         xr;
		logic [CNT_W-1:0]   ones;
		logic [BYTES_W-1:0] cnt;
		logic               ovf;
		logic [MODE_W-1:0]  mode;
	} snap_t;

	function automatic op_t mode_op(input logic [MODE_W-1:0] m);
		op_t op;
		case (m)
			MODE_SUM_RIGHT:          op = OP_SUM_R;
			MODE_SUM_LEFT:           op = OP_SUM_L;
			MODE_XOR:                op = OP_XOR;
			MODE_COUNT1_RIGHT:       op = OP_C1_R;
			MODE_COUNT1_LEFT:        op = OP_C1_L;
			MODE_COUNT0_RIGHT:       op = OP_C0_R;
			MODE_COUNT0_LEFT:        op = OP_C0_L;
			MODE_FLIP_SUM_RIGHT:     op = OP_SUM_R;
			MODE_FLIP_SUM_LEFT:      op = OP_SUM_L;
			MODE_REV_SUM_RIGHT:      op = OP_SUM_R;
			MODE_REV_SUM_LEFT:       op = OP_SUM_L;
			MODE_FLIP_REV_SUM_RIGHT: op = OP_SUM_R;
			MODE_FLIP_REV_SUM_LEFT:  op = OP_SUM_L;
			MODE_FLIP_REV_XOR:       op = OP_XOR;
			default:                 op = OP_NONE;
		endcase
		return op;
	endfunction

	function automatic tf_t mode_tf(input logic [MODE_W-1:0] m);
		tf_t tf;
		case (m)
			MODE_FLIP_SUM_RIGHT,
			MODE_FLIP_SUM_LEFT:      tf = '{flip: 1'b1, rev: 1'b0};
			MODE_REV_SUM_RIGHT,
			MODE_REV_SUM_LEFT:       tf = '{flip: 1'b0, rev: 1'b1};
			MODE_FLIP_REV_SUM_RIGHT,
			MODE_FLIP_REV_SUM_LEFT,
			MODE_FLIP_REV_XOR:       tf = '{flip: 1'b1, rev: 1'b1};
			default:                 tf = '{flip: 1'b0, rev: 1'b0};
		endcase
		return tf;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'b000, b[i]};
		end
		return c;
	endfunction

	// Invert first, then bit-reverse.
	function automatic logic [7:0] xform(input logic [7:0] b, input tf_t tf);
		logic [7:0] r;
		r = tf.flip ? ~b : b;
		if (tf.rev) begin
			r = rev8(r);
		end
		return r;
	endfunction

	// Top 8 bits of the minimal binary form; values below 256 pass whole.
	function automatic logic [7:0] take_left(input logic [SUM_W-1:0] v);
		logic [SHIFT_W-1:0] sh;
		logic [SUM_W-1:0]   w;
		sh = '0;
		for (int i = 8; i < SUM_W; i++) begin
			if (v[i]) begin
				sh = SHIFT_W'(i - 7);
			end
		end
		w = v >> sh;
		return w[7:0];
	endfunction

endpackage

[hw/rtl/cbc_accum.sv]
`timescale 1ns / 1ps

// Input register plus per-message accumulators. On the last byte of a
// message the updated totals go out as a snapshot and the state clears.
module cbc_accum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  cbc_pkg::in_item_t               byte_item,
	input  logic [cbc_pkg::MODE_W-1:0]      mode,
	input  logic                            snap_free,
	output cbc_pkg::snap_t                  snap
);

	logic                            valid_s1;
	cbc_pkg::in_item_t               item_s1;
	logic                            s1_go;
	logic                            byte_acc;

	logic [cbc_pkg::SUM_W-1:0]       sum_q,  sum_n;
	logic [7:0]                      xor_q,  xor_n;
	logic [cbc_pkg::CNT_W-1:0]       ones_q, ones_n;
	logic [cbc_pkg::BYTES_W-1:0]     cnt_q,  cnt_n;
	logic                            ovf_q,  ovf_n;
	logic [7:0]                      tbyte;
	logic                            room;

	// A last byte waits for the result stage; other bytes never wait.
	assign s1_go      = valid_s1 && (!item_s1.last || snap_free);
	assign byte_stall = valid_s1 && !s1_go;
	assign byte_acc   = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			item_s1 <= byte_item;
		end
	end

	always_comb begin
		room   = cnt_q < cbc_pkg::BYTES_W'(cbc_pkg::MAX_BYTES);
		tbyte  = cbc_pkg::xform(item_s1.data_byte, cbc_pkg::mode_tf(mode));
		sum_n  = sum_q;
		xor_n  = xor_q;
		ones_n = ones_q;
		cnt_n  = cnt_q;
		ovf_n  = ovf_q;
		if (room) begin
			sum_n  = sum_q + cbc_pkg::SUM_W'(tbyte);
			xor_n  = xor_q ^ tbyte;
			ones_n = ones_q + cbc_pkg::CNT_W'(cbc_pkg::pop8(item_s1.data_byte));
			cnt_n  = cnt_q + cbc_pkg::BYTES_W'(1);
		end else begin
			ovf_n  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			xor_q  <= '0;
			ones_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (s1_go) begin
			if (item_s1.last) begin
				sum_q  <= '0;
				xor_q  <= '0;
				ones_q <= '0;
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				sum_q  <= sum_n;
				xor_q  <= xor_n;
				ones_q <= ones_n;
				cnt_q  <= cnt_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	always_comb begin
		snap.valid = s1_go && item_s1.last;
		snap.sum   = sum_n;
		snap.xr    = xor_n;
		snap.ones  = ones_n;
		snap.cnt   = cnt_n;
		snap.ovf   = ovf_n;
		snap.mode  = mode;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cbc_pkg::BYTES_W'(cbc_pkg::MAX_BYTES))
		else $error("byte count past limit");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == cbc_pkg::BYTES_W'(cbc_pkg::MAX_BYTES))
		else $error("overflow set before message full");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && item_s1.last |=> cnt_q == '0 && sum_q == '0 && !ovf_q)
		else $error("accumulators not cleared after last byte");

endmodule

[hw/rtl/configurable_byte_checksum_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// byte      in   byte_valid/stall     byte_item  (data_byte, last)
// sum       out  sum_valid/stall      sum_item   (check_byte, overflow)
// cfg       in   cfg_valid/ready      cfg_data   (mode, 4 bits)
//
// One byte per cycle sustained while byte_stall is low. A byte sits in the input register
// where the accumulators add it; a last byte also moves its totals into the result stage,
// and the checksum then lands in the output register.
// Async active-low reset clears all valids, the accumulators and mode (0).
// A stalled result blocks only the last-byte path; ordinary bytes keep
// flowing until a finished message finds both result registers full.
module configurable_byte_checksum_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  cbc_pkg::in_item_t           byte_item,
	output logic                        sum_valid,
	input  logic                        sum_stall,
	output cbc_pkg::out_item_t          sum_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cbc_pkg::MODE_W-1:0]  cfg_data
);

	logic [cbc_pkg::MODE_W-1:0] mode_q;
	cbc_pkg::snap_t             snap;
	cbc_pkg::snap_t             snap_s2;
	logic                       out_free;
	logic                       s2_go;
	logic                       s2_free;

	cbc_pkg::op_t               op_s2;
	cbc_pkg::tf_t               tf_s2;
	logic [cbc_pkg::CNT_W-1:0]  zeros_s2;
	logic [cbc_pkg::SUM_W-1:0]  wide_s2;
	logic [7:0]                 raw_s2;
	logic                       left_s2;
	cbc_pkg::out_item_t         res_s2;

	// Mode register; the user must write it only while idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cbc_pkg::MODE_SUM_RIGHT;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Output register frees when empty or taken this cycle.
	assign out_free = !sum_valid || !sum_stall;
	assign s2_go    = snap_s2.valid && out_free;
	assign s2_free  = !snap_s2.valid || out_free;

	cbc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.mode       (mode_q),
		.snap_free  (s2_free),
		.snap       (snap)
	);

	// Result stage: holds the totals of one finished message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_s2 <= '0;
		end else if (snap.valid) begin
			snap_s2 <= snap;
		end else if (s2_go) begin
			snap_s2.valid <= 1'b0;
		end
	end

	// Pick the core value, take RIGHT or LEFT, then post-transform.
	always_comb begin
		op_s2    = cbc_pkg::mode_op(snap_s2.mode);
		tf_s2    = cbc_pkg::mode_tf(snap_s2.mode);
		zeros_s2 = cbc_pkg::CNT_W'({snap_s2.cnt, 3'b000}) - snap_s2.ones;
		wide_s2  = '0;
		left_s2  = 1'b0;
		case (op_s2)
			cbc_pkg::OP_SUM_R: wide_s2 = snap_s2.sum;
			cbc_pkg::OP_SUM_L: begin
				wide_s2 = snap_s2.sum;
				left_s2 = 1'b1;
			end
			cbc_pkg::OP_XOR:   wide_s2 = cbc_pkg::SUM_W'(snap_s2.xr);
			cbc_pkg::OP_C1_R:  wide_s2 = cbc_pkg::SUM_W'(snap_s2.ones);
			cbc_pkg::OP_C1_L: begin
				wide_s2 = cbc_pkg::SUM_W'(snap_s2.ones);
				left_s2 = 1'b1;
			end
			cbc_pkg::OP_C0_R:  wide_s2 = cbc_pkg::SUM_W'(zeros_s2);
			cbc_pkg::OP_C0_L: begin
				wide_s2 = cbc_pkg::SUM_W'(zeros_s2);
				left_s2 = 1'b1;
			end
			default:           wide_s2 = '0;
		endcase
		raw_s2 = left_s2 ? cbc_pkg::take_left(wide_s2) : wide_s2[7:0];
		res_s2.check_byte = cbc_pkg::xform(raw_s2, tf_s2);
		res_s2.overflow   = snap_s2.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid <= 1'b0;
		end else if (out_free) begin
			sum_valid <= snap_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && snap_s2.valid) begin
			sum_item <= res_s2;
		end
	end

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_s2.valid && !out_free |=> snap_s2.valid && $stable(snap_s2))
		else $error("result stage lost a transaction while blocked");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum_stall && !snap_s2.valid |=> !sum_valid)
		else $error("result repeated after transaction");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> snap_s2.valid && !out_free)
		else $error("input stalled while result path free");

endmodule
